@@ hdl/fcl_pkg.sv @@
// shared types, widths and codes of the frontier cell labeler
package fcl_pkg;

  // default grid limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // field widths
  localparam int VALUE_W   = 8;
  localparam int SIZE_W    = 11;
  localparam int FIX_W     = 32;
  localparam int IDX_OUT_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CODE_W    = 2;
  localparam int WIN_W     = 9 * CODE_W;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd4;

  // configuration reset values
  localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 11'd1024;
  localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 11'd1024;
  localparam logic [FIX_W-1:0]  CELL_SIZE_RST   = 32'd3277;

  // cell class codes
  localparam logic [CODE_W-1:0] CODE_MASKED  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 2'd1;
  localparam logic [CODE_W-1:0] CODE_FREE    = 2'd2;
  localparam logic [CODE_W-1:0] CODE_KNOWN   = 2'd3;

  // raw occupancy values
  localparam logic [VALUE_W-1:0] VALUE_UNKNOWN = 8'hFF;
  localparam logic [VALUE_W-1:0] VALUE_FREE    = 8'h00;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // per-word verdict flags passed from front to back
  typedef struct packed {
    logic last;
    logic valid;
    logic frontier;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

endpackage

@@ hdl/fcl_ram.sv @@
// generic single-port-write, registered-read ram
module fcl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/fcl_front.sv @@
// front end: position counters, line stores, 3x3 window and frontier verdict
module fcl_front #(
  parameter int MAX_WIDTH  = fcl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fcl_pkg::MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_fire,
  input  logic [fcl_pkg::VALUE_W-1:0]        cell_value,
  input  logic                               frame_start,
  input  logic [fcl_pkg::SIZE_W-1:0]         grid_width,
  input  logic [fcl_pkg::SIZE_W-1:0]         grid_height,
  output logic                               busy,
  output logic                               push,
  output logic [CW-1:0]                      push_col,
  output logic [RW-1:0]                      push_row,
  output fcl_pkg::flags_t                    push_flags
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int GWC = (CW > fcl_pkg::SIZE_W) ? CW : fcl_pkg::SIZE_W;
  localparam int GWR = (RW > fcl_pkg::SIZE_W) ? RW : fcl_pkg::SIZE_W;
  localparam int CODE_W = fcl_pkg::CODE_W;

  // clamped sizes
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = CW'(1);
    end else if (GWC'(grid_width) > GWC'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = RW'(1);
    end else if (GWR'(grid_height) > GWR'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(grid_height);
    end
  end

  // position counters
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          in_col, in_row, need_mid, need_top, cur_valid, cur_last;
  logic [CODE_W-1:0] cur_code;

  assign c_cur = frame_start ? '0 : col_cnt_r;
  assign r_cur = frame_start ? '0 : row_cnt_r;

  always_comb begin
    in_col    = c_cur < w_eff;
    in_row    = r_cur < h_eff;
    need_mid  = in_col && (r_cur != '0) && (r_cur <= h_eff);
    need_top  = in_col && (r_cur > RW'(1)) && ((RW + 1)'(r_cur) <= (RW + 1)'(h_eff) + 1'b1);
    cur_valid = (c_cur != '0) && (r_cur != '0) && (c_cur <= w_eff) && (r_cur <= h_eff);
    cur_last  = (c_cur == w_eff) && (r_cur == h_eff);
    if (!(in_col && in_row)) begin
      cur_code = fcl_pkg::CODE_MASKED;
    end else if (cell_value == fcl_pkg::VALUE_UNKNOWN) begin
      cur_code = fcl_pkg::CODE_UNKNOWN;
    end else if (cell_value == fcl_pkg::VALUE_FREE) begin
      cur_code = fcl_pkg::CODE_FREE;
    end else begin
      cur_code = fcl_pkg::CODE_KNOWN;
    end
    if (c_cur >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_cur >= h_eff) ? '0 : r_cur + 1'b1;
    end else begin
      col_cnt_nxt = c_cur + 1'b1;
      row_cnt_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_fire) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // stage one: line store read in flight
  logic              s1_v_r;
  logic [CW-1:0]     s1_col_r;
  logic [RW-1:0]     s1_row_r;
  logic [CODE_W-1:0] s1_cur_r;
  logic              s1_mid_r, s1_top_r, s1_we_r, s1_valid_r, s1_last_r;
  logic [AW-1:0]     s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r   <= c_cur;
      s1_row_r   <= r_cur;
      s1_cur_r   <= cur_code;
      s1_mid_r   <= need_mid;
      s1_top_r   <= need_top;
      s1_we_r    <= in_col && in_row;
      s1_valid_r <= cur_valid;
      s1_last_r  <= cur_last;
      s1_addr_r  <= AW'(c_cur);
    end
  end

  // both line stores share one word: row above low, two rows above high
  logic [2*CODE_W-1:0] ls_rdata;
  logic [CODE_W-1:0]   mid_code, top_code;

  assign mid_code = s1_mid_r ? ls_rdata[CODE_W-1:0] : fcl_pkg::CODE_MASKED;
  assign top_code = s1_top_r ? ls_rdata[2*CODE_W-1:CODE_W] : fcl_pkg::CODE_MASKED;

  fcl_ram #(
    .WIDTH (2 * CODE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_v_r && s1_we_r),
    .waddr (s1_addr_r),
    .wdata ({mid_code, s1_cur_r}),
    .re    (in_fire),
    .raddr (AW'(c_cur)),
    .rdata (ls_rdata)
  );

  // stage two: window shift and verdict
  logic [fcl_pkg::WIN_W-1:0] window_r, window_nxt;
  logic [3*CODE_W-1:0]       new_col;
  logic                      has_unk, has_free, cen_known;

  always_comb begin
    new_col = {s1_cur_r, mid_code, top_code};
    if (s1_col_r == '0) begin
      window_nxt = {new_col, {(2 * 3 * CODE_W){1'b0}}};
    end else begin
      window_nxt = {new_col, window_r[fcl_pkg::WIN_W-1:3*CODE_W]};
    end
    has_unk  = 1'b0;
    has_free = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (window_nxt[k*CODE_W +: CODE_W] == fcl_pkg::CODE_UNKNOWN) begin
        has_unk = 1'b1;
      end
      if (window_nxt[k*CODE_W +: CODE_W] == fcl_pkg::CODE_FREE) begin
        has_free = 1'b1;
      end
    end
    // centre is middle row of middle column
    cen_known = window_nxt[4*CODE_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_v_r) begin
      window_r <= window_nxt;
    end
  end

  assign busy                = s1_v_r;
  assign push                = s1_v_r;
  assign push_col            = s1_col_r - 1'b1;
  assign push_row            = s1_row_r - 1'b1;
  assign push_flags.last     = s1_valid_r && s1_last_r;
  assign push_flags.valid    = s1_valid_r;
  assign push_flags.frontier = s1_valid_r && cen_known && has_unk && has_free;

endmodule

@@ hdl/fcl_queue.sv @@
// small fifo between the front and back ends
module fcl_queue #(
  parameter int WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [WIDTH-1:0]            push_data,
  input  logic                        pop,
  output logic                        head_valid,
  output logic [WIDTH-1:0]            head_data,
  output logic [fcl_pkg::QCNT_W-1:0]  count
);

  localparam int PW = $clog2(fcl_pkg::QDEPTH);

  logic [WIDTH-1:0]            slot_r [fcl_pkg::QDEPTH];
  logic [PW-1:0]               wr_ptr_r, rd_ptr_r;
  logic [fcl_pkg::QCNT_W-1:0]  count_r;
  logic                        do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = count_r != '0;
  assign head_data  = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

@@ hdl/fcl_back.sv @@
// back end: world coordinates with saturation and output register
module fcl_back #(
  parameter int MAX_WIDTH  = fcl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fcl_pkg::MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  logic [CW-1:0]                  head_col,
  input  logic [RW-1:0]                  head_row,
  input  fcl_pkg::flags_t                head_flags,
  output logic                           pop,
  input  logic [fcl_pkg::FIX_W-1:0]      cell_size,
  input  logic [fcl_pkg::FIX_W-1:0]      origin_x,
  input  logic [fcl_pkg::FIX_W-1:0]      origin_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fcl_pkg::IDX_OUT_W-1:0]  cell_col,
  output logic [fcl_pkg::IDX_OUT_W-1:0]  cell_row,
  output logic [fcl_pkg::FIX_W-1:0]      world_x,
  output logic [fcl_pkg::FIX_W-1:0]      world_y,
  output fcl_pkg::flags_t                flags
);

  localparam int FW  = fcl_pkg::FIX_W;
  localparam int PXW = CW + FW;
  localparam int PYW = RW + FW;
  localparam int SXW = PXW + 2;
  localparam int SYW = PYW + 2;

  // multiply stage
  logic                m_v_r;
  logic [CW-1:0]       m_col_r;
  logic [RW-1:0]       m_row_r;
  fcl_pkg::flags_t     m_flags_r;
  logic [PXW-1:0]      m_px_r;
  logic [PYW-1:0]      m_py_r;
  logic                o_v_r;
  logic                o_adv, m_adv;

  assign o_adv = !o_v_r || out_ready;
  assign m_adv = !m_v_r || o_adv;
  assign pop   = head_valid && m_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_adv) begin
      m_v_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_col_r   <= head_col;
      m_row_r   <= head_row;
      m_flags_r <= head_flags;
      m_px_r    <= PXW'(head_col) * PXW'(cell_size);
      m_py_r    <= PYW'(head_row) * PYW'(cell_size);
    end
  end

  // add origin and clip to signed 32 bits
  logic signed [SXW-1:0] sum_x;
  logic signed [SYW-1:0] sum_y;
  logic [FW-1:0]         sat_x, sat_y;

  assign sum_x = $signed({2'b00, m_px_r}) + SXW'($signed(origin_x));
  assign sum_y = $signed({2'b00, m_py_r}) + SYW'($signed(origin_y));

  always_comb begin
    if (!sum_x[SXW-1] && (|sum_x[SXW-2:FW-1])) begin
      sat_x = {1'b0, {(FW - 1){1'b1}}};
    end else if (sum_x[SXW-1] && !(&sum_x[SXW-2:FW-1])) begin
      sat_x = {1'b1, {(FW - 1){1'b0}}};
    end else begin
      sat_x = sum_x[FW-1:0];
    end
    if (!sum_y[SYW-1] && (|sum_y[SYW-2:FW-1])) begin
      sat_y = {1'b0, {(FW - 1){1'b1}}};
    end else if (sum_y[SYW-1] && !(&sum_y[SYW-2:FW-1])) begin
      sat_y = {1'b1, {(FW - 1){1'b0}}};
    end else begin
      sat_y = sum_y[FW-1:0];
    end
  end

  // output register, all zero for a non-grid centre
  logic [fcl_pkg::IDX_OUT_W-1:0] o_col_r, o_row_r;
  logic [FW-1:0]                 o_wx_r, o_wy_r;
  fcl_pkg::flags_t               o_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_adv) begin
      o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && m_v_r) begin
      o_flags_r <= m_flags_r;
      if (m_flags_r.valid) begin
        o_col_r <= fcl_pkg::IDX_OUT_W'(m_col_r);
        o_row_r <= fcl_pkg::IDX_OUT_W'(m_row_r);
        o_wx_r  <= sat_x;
        o_wy_r  <= sat_y;
      end else begin
        o_col_r <= '0;
        o_row_r <= '0;
        o_wx_r  <= '0;
        o_wy_r  <= '0;
      end
    end
  end

  assign out_valid = o_v_r;
  assign cell_col  = o_col_r;
  assign cell_row  = o_row_r;
  assign world_x   = o_wx_r;
  assign world_y   = o_wy_r;
  assign flags     = o_flags_r;

endmodule

@@ hdl/frontier_cell_labeler.sv @@
// top level of the streaming 3x3 frontier cell labeler
//
// usage
//   in_*  : one occupancy cell per word in raster order; each row holds
//           grid_width real cells plus one padding column, and one padding
//           row follows the grid_height real rows. in_tuser marks the first
//           cell of a frame and restarts the position counters.
//   out_* : exactly one word per input word, judging the cell one row above
//           and one column left of the arriving one. centre_valid is low
//           (and every other field zero) on the first column and first row.
//           out_tlast flags the last real cell of the grid.
//   cfg_* : register writes, always ready; write only while the block is idle.
// timing
//   an accepted word passes line store read, window update and queue write,
//   multiply, then saturating add into the output register. throughput is
//   one word per cycle unless out_tready stalls, set by one line store read
//   and one write per cell and a 4-entry queue between front and back.
// reset and stalls
//   rst_n clears counters, window and queue; line store entries are not
//   cleared, no clearing pass is run. when out_tready is low the output
//   register holds, the back end and queue fill, and in_tready drops once
//   the queue plus the word in flight would exceed its depth.
module frontier_cell_labeler #(
  parameter int MAX_WIDTH  = fcl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fcl_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fcl_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] cell_value
  input  logic [0:0]                         in_tuser,   // [0] frame_start
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fcl_pkg::OUT_DATA_W-1:0]     out_tdata,  // [9:0] cell_col, [19:10] cell_row,
                                                         // [51:20] world_x, [83:52] world_y,
                                                         // [87:84] zero
  output logic [fcl_pkg::OUT_USER_W-1:0]     out_tuser,  // [0] is_frontier, [1] centre_valid
  output logic                               out_tlast,  // frame_last
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcl_pkg::FIX_W-1:0]          cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int QW = CW + RW + fcl_pkg::FLAGS_W;
  localparam int FW = fcl_pkg::FIX_W;

  // configuration registers
  logic [fcl_pkg::SIZE_W-1:0] grid_width_r, grid_height_r;
  logic [FW-1:0]              cell_size_r, origin_x_r, origin_y_r;
  logic                       cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= fcl_pkg::GRID_WIDTH_RST;
      grid_height_r <= fcl_pkg::GRID_HEIGHT_RST;
      cell_size_r   <= fcl_pkg::CELL_SIZE_RST;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        fcl_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[fcl_pkg::SIZE_W-1:0];
        fcl_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[fcl_pkg::SIZE_W-1:0];
        fcl_pkg::REG_CELL_SIZE:   cell_size_r   <= cfg_data;
        fcl_pkg::REG_ORIGIN_X:    origin_x_r    <= cfg_data;
        fcl_pkg::REG_ORIGIN_Y:    origin_y_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // admission: queue entries plus the word in the front stage must fit
  logic                       in_fire, front_busy;
  logic [fcl_pkg::QCNT_W-1:0] q_count;

  assign in_tready = (q_count + fcl_pkg::QCNT_W'(front_busy)) < fcl_pkg::QCNT_W'(fcl_pkg::QDEPTH);
  assign in_fire   = in_tvalid && in_tready;

  // front end
  logic            push;
  logic [CW-1:0]   push_col;
  logic [RW-1:0]   push_row;
  fcl_pkg::flags_t push_flags;

  fcl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .cell_value  (in_tdata[fcl_pkg::VALUE_W-1:0]),
    .frame_start (in_tuser[0]),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .busy        (front_busy),
    .push        (push),
    .push_col    (push_col),
    .push_row    (push_row),
    .push_flags  (push_flags)
  );

  // decoupling queue
  logic          pop, head_valid;
  logic [QW-1:0] head_data;

  fcl_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_col, push_row, push_flags}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  // back end
  logic [fcl_pkg::IDX_OUT_W-1:0] cell_col, cell_row;
  logic [FW-1:0]                 world_x, world_y;
  fcl_pkg::flags_t               out_flags;

  fcl_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_col   (head_data[QW-1 -: CW]),
    .head_row   (head_data[fcl_pkg::FLAGS_W +: RW]),
    .head_flags (fcl_pkg::flags_t'(head_data[fcl_pkg::FLAGS_W-1:0])),
    .pop        (pop),
    .cell_size  (cell_size_r),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .world_x    (world_x),
    .world_y    (world_y),
    .flags      (out_flags)
  );

  // output packing
  assign out_tdata = {4'b0000, world_y, world_x, cell_row, cell_col};
  assign out_tuser = {out_flags.valid, out_flags.frontier};
  assign out_tlast = out_flags.last;

endmodule

@@ hdl/fcl_checker.sv @@
// port-level checker for the frontier cell labeler, with its bind
module fcl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fcl_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [fcl_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tlast
);

  // no result word shows right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result word changed while stalled");

  // a non-grid centre carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == '0 && !out_tuser[0] && !out_tlast)
    else $error("non-grid centre with nonzero fields");

  // frontier and frame end only on real cells
  a_flags_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tlast) |-> out_tuser[1])
    else $error("frontier or last flag on non-grid centre");

endmodule

bind frontier_cell_labeler fcl_checker u_fcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ test/frontier_cell_labeler_test.sv @@
// self-checking testbench for the streaming 3x3 frontier cell labeler
`timescale 1ns / 100ps

module frontier_cell_labeler_test;

  localparam int LATENCY      = 3;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_WORDS = 1100;

  // index with no register behind it, writes there are dropped
  localparam logic [fcl_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // hand-made 4x4 grid, row by row, each row closed by its padding word,
  // then the padding row; out-of-range values and junk on the padding
  localparam logic [fcl_pkg::VALUE_W-1:0] DIRECTED_VALUES [0:24] = '{
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'hA5,
    8'hFF, 8'h32, 8'h00, 8'h64, 8'h00,
    8'h7F, 8'h80, 8'h00, 8'h01, 8'hFF,
    8'h00, 8'hFE, 8'hFF, 8'h64, 8'h5A,
    8'hFF, 8'h00, 8'h80, 8'h7F, 8'h3C
  };

  // what the block should say about one centre
  typedef struct packed {
    logic [fcl_pkg::IDX_OUT_W-1:0] col;
    logic [fcl_pkg::IDX_OUT_W-1:0] row;
    logic [fcl_pkg::FIX_W-1:0]     wx;
    logic [fcl_pkg::FIX_W-1:0]     wy;
    logic                          frontier;
    logic                          centre_ok;
    logic                          last;
  } verdict_t;

  // bit-level predictor of the labeler plus the queue of verdicts still due
  class frontier_predictor;
    logic [fcl_pkg::SIZE_W-1:0] width_reg  = fcl_pkg::GRID_WIDTH_RST;
    logic [fcl_pkg::SIZE_W-1:0] height_reg = fcl_pkg::GRID_HEIGHT_RST;
    logic [fcl_pkg::FIX_W-1:0]  size_reg   = fcl_pkg::CELL_SIZE_RST;
    logic [fcl_pkg::FIX_W-1:0]  org_x_reg  = '0;
    logic [fcl_pkg::FIX_W-1:0]  org_y_reg  = '0;
    logic [fcl_pkg::CODE_W-1:0] row_above [fcl_pkg::MAX_WIDTH_DEF];
    logic [fcl_pkg::CODE_W-1:0] two_above [fcl_pkg::MAX_WIDTH_DEF];
    logic [fcl_pkg::WIN_W-1:0]  window     = '0;
    int unsigned                col_cnt    = 0;
    int unsigned                row_cnt    = 0;
    verdict_t                   verdicts_due [$];
    int                         errors     = 0;

    function int unsigned clamp_dim(logic [fcl_pkg::SIZE_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    // index times cell size plus origin, saturated to signed 32 bits
    function logic [fcl_pkg::FIX_W-1:0] place(int unsigned idx,
                                              logic [fcl_pkg::FIX_W-1:0] org);
      longint sum;
      longint sz;
      longint o;
      sz = size_reg;
      o = $signed(org);
      sum = longint'(idx) * sz + o;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[fcl_pkg::FIX_W-1:0];
    endfunction

    function void write_reg(logic [fcl_pkg::CFG_IDX_W-1:0] idx,
                            logic [fcl_pkg::FIX_W-1:0] data);
      case (idx)
        fcl_pkg::REG_GRID_WIDTH:  width_reg  = data[fcl_pkg::SIZE_W-1:0];
        fcl_pkg::REG_GRID_HEIGHT: height_reg = data[fcl_pkg::SIZE_W-1:0];
        fcl_pkg::REG_CELL_SIZE:   size_reg   = data;
        fcl_pkg::REG_ORIGIN_X:    org_x_reg  = data;
        fcl_pkg::REG_ORIGIN_Y:    org_y_reg  = data;
        default: ;
      endcase
    endfunction

    // one accepted word in, one verdict queued
    function void take_word(logic [fcl_pkg::VALUE_W-1:0] v, logic restart);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [fcl_pkg::CODE_W-1:0] cur;
      logic [fcl_pkg::CODE_W-1:0] mid;
      logic [fcl_pkg::CODE_W-1:0] top;
      logic in_col;
      logic unk;
      logic fre;
      logic known;
      logic ok;
      verdict_t e;
      w = clamp_dim(width_reg, fcl_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, fcl_pkg::MAX_HEIGHT_DEF);
      if (restart) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      c = col_cnt;
      r = row_cnt;
      in_col = (c < w);
      cur = fcl_pkg::CODE_MASKED;
      mid = fcl_pkg::CODE_MASKED;
      top = fcl_pkg::CODE_MASKED;
      if (in_col && r < h) begin
        if (v == fcl_pkg::VALUE_UNKNOWN) cur = fcl_pkg::CODE_UNKNOWN;
        else if (v == fcl_pkg::VALUE_FREE) cur = fcl_pkg::CODE_FREE;
        else cur = fcl_pkg::CODE_KNOWN;
      end
      if (in_col && r >= 1 && r - 1 < h) mid = row_above[c];
      if (in_col && r >= 2 && r - 2 < h) top = two_above[c];
      if (in_col && r < h) begin
        two_above[c] = mid;
        row_above[c] = cur;
      end
      if (c == 0) window = {cur, mid, top, 12'b0};
      else window = {cur, mid, top, window[fcl_pkg::WIN_W-1:6]};
      unk = 1'b0;
      fre = 1'b0;
      for (int k = 0; k < 9; k++) begin
        if (window[2*k +: 2] == fcl_pkg::CODE_UNKNOWN) unk = 1'b1;
        if (window[2*k +: 2] == fcl_pkg::CODE_FREE) fre = 1'b1;
      end
      known = (window[9:8] >= fcl_pkg::CODE_FREE);
      ok = (c >= 1) && (r >= 1) && (c - 1 < w) && (r - 1 < h);
      e = '0;
      if (ok) begin
        e.col       = fcl_pkg::IDX_OUT_W'(c - 1);
        e.row       = fcl_pkg::IDX_OUT_W'(r - 1);
        e.wx        = place(c - 1, org_x_reg);
        e.wy        = place(r - 1, org_y_reg);
        e.frontier  = known && unk && fre;
        e.centre_ok = 1'b1;
        e.last      = (c == w) && (r == h);
      end
      verdicts_due = {verdicts_due, e};
      if (c >= w) begin
        col_cnt = 0;
        row_cnt = (r >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    // one line per mismatch, every one counted
    task flag_error(string what, longint unsigned got, longint unsigned want);
      $display("error at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_verdict(logic [fcl_pkg::OUT_DATA_W-1:0] data,
                       logic [fcl_pkg::OUT_USER_W-1:0] user, logic last);
      verdict_t e;
      if (verdicts_due.size() == 0) begin
        flag_error("result word with nothing due", data[19:0], 0);
        return;
      end
      e = verdicts_due.pop_front();
      if (data[9:0] !== e.col) flag_error("cell_col", data[9:0], e.col);
      if (data[19:10] !== e.row) flag_error("cell_row", data[19:10], e.row);
      if (data[51:20] !== e.wx) flag_error("world_x", data[51:20], e.wx);
      if (data[83:52] !== e.wy) flag_error("world_y", data[83:52], e.wy);
      if (data[87:84] !== 4'b0) flag_error("tdata padding", data[87:84], 0);
      if (user[0] !== e.frontier) flag_error("is_frontier", user[0], e.frontier);
      if (user[1] !== e.centre_ok) flag_error("centre_valid", user[1], e.centre_ok);
      if (last !== e.last) flag_error("frame_last", last, e.last);
    endtask

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [fcl_pkg::IN_DATA_W-1:0]   in_tdata   = '0;   // [7:0] cell_value
  logic [0:0]                      in_tuser   = '0;   // [0] frame_start
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fcl_pkg::OUT_DATA_W-1:0]  out_tdata;         // [9:0] col, [19:10] row, [51:20] x,
                                                      // [83:52] y
  logic [fcl_pkg::OUT_USER_W-1:0]  out_tuser;         // [0] is_frontier, [1] centre_valid
  logic                            out_tlast;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [fcl_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [fcl_pkg::FIX_W-1:0]       cfg_data   = '0;

  frontier_predictor model = new();

  // stimulus knobs, set by the main sequence
  bit          src_gaps    = 1'b0;
  bit          sink_stalls = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned cur_w       = 1;
  int unsigned cur_h       = 1;
  int unsigned words_sent  = 0;
  int unsigned cycle_cnt   = 0;

  frontier_cell_labeler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // handshake monitor: register writes, accepted words, result words,
  // in that order so a write always lands before the word after it
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) model.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) model.take_word(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) model.check_verdict(out_tdata, out_tuser, out_tlast);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // occupancy value: lots of unknown and free so frontiers show up,
  // the rest occupied levels or any byte at all
  function automatic logic [fcl_pkg::VALUE_W-1:0] pick_value();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 35) return fcl_pkg::VALUE_UNKNOWN;
    if (p < 70) return fcl_pkg::VALUE_FREE;
    if (p < 90) return fcl_pkg::VALUE_W'($urandom_range(1, 100));
    return fcl_pkg::VALUE_W'($urandom);
  endfunction

  function automatic logic [fcl_pkg::FIX_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h0001_0000;
      4: return $urandom_range(1, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [fcl_pkg::FIX_W-1:0] pick_origin();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // result side: ready most of the time, random stalls, one long hold-off
  initial begin : sink
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (sink_stalls ? $urandom_range(1, 6) : 1) @(posedge clk);
      end
    end
  end

  // offer one word and wait until it is taken; tvalid stays up afterwards
  // so back-to-back words need no second assignment in one step
  task automatic send_word(input logic [fcl_pkg::VALUE_W-1:0] v, input logic restart);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= v;
    in_tuser[0] <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // whole frame at the current size, padding column and row included;
  // restart_pct gives stray restarts in per mille
  task automatic send_frame(input logic lead_restart, input int restart_pct);
    logic restart;
    for (int unsigned r = 0; r <= cur_h; r++) begin
      for (int unsigned c = 0; c <= cur_w; c++) begin
        if (r == 0 && c == 0) restart = lead_restart;
        else restart = ($urandom_range(0, 999) < restart_pct);
        send_word(pick_value(), restart);
      end
    end
  endtask

  // stop sending and let every due verdict come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fcl_pkg::FIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all five registers; width and height words may carry junk above bit 10
  task automatic program_grid(input logic [fcl_pkg::FIX_W-1:0] w_word,
                              input logic [fcl_pkg::FIX_W-1:0] h_word,
                              input logic [fcl_pkg::FIX_W-1:0] size,
                              input logic [fcl_pkg::FIX_W-1:0] ox,
                              input logic [fcl_pkg::FIX_W-1:0] oy);
    write_reg(fcl_pkg::REG_GRID_WIDTH, w_word);
    write_reg(fcl_pkg::REG_GRID_HEIGHT, h_word);
    write_reg(fcl_pkg::REG_CELL_SIZE, size);
    write_reg(fcl_pkg::REG_ORIGIN_X, ox);
    write_reg(fcl_pkg::REG_ORIGIN_Y, oy);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_w = model.clamp_dim(w_word[fcl_pkg::SIZE_W-1:0], fcl_pkg::MAX_WIDTH_DEF);
    cur_h = model.clamp_dim(h_word[fcl_pkg::SIZE_W-1:0], fcl_pkg::MAX_HEIGHT_DEF);
  endtask

  function automatic logic [fcl_pkg::FIX_W-1:0] dim_word(int unsigned d);
    logic [fcl_pkg::FIX_W-1:0] word;
    word = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
    word[fcl_pkg::SIZE_W-1:0] = fcl_pkg::SIZE_W'(d);
    return word;
  endfunction

  initial begin : main
    int unsigned goal;
    int unsigned w;
    int unsigned h;
    int n;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed 4x4 grid, 1.0 m cells, negative x origin
    write_reg(REG_UNMAPPED, $urandom);
    program_grid(32'd4, 32'd4, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000);
    for (int i = 0; i < 25; i++) send_word(DIRECTED_VALUES[i], i == 0);
    drain();

    // zero sizes clamp to one cell, origins at both ends of the range
    program_grid(32'hFFFF_F800, 32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_frame(i == 0, 0);
    drain();
    program_grid(32'd1, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int i = 0; i < 3; i++) send_frame(i == 0, 0);
    drain();

    // long output hold-off while words keep coming, so the input stalls
    program_grid(32'd10, 32'd6, 32'd3277, pick_origin(), pick_origin());
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_req = 1'b1;
    send_frame(1'b1, 0);
    drain();

    // size shrinks in mid-frame: counters past the new width and height
    // are taken as padding and wrap to a new frame
    program_grid(32'd8, 32'd8, pick_size(), pick_origin(), pick_origin());
    for (int i = 0; i < 50; i++) send_word(pick_value(), i == 0);
    drain();
    program_grid(32'd3, 32'd2, pick_size(), pick_origin(), pick_origin());
    for (int i = 0; i < 30; i++) send_word(pick_value(), 1'b0);
    drain();

    // random grids, mostly small, whole frames with random content
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      n = $urandom_range(0, 99);
      if (n < 5) w = 0;
      else if (n < 75) w = $urandom_range(1, 8);
      else w = $urandom_range(9, 40);
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
      program_grid(dim_word(w), dim_word(h), pick_size(), pick_origin(), pick_origin());
      src_gaps = ($urandom_range(0, 2) != 0);
      sink_stalls = ($urandom_range(0, 2) != 0);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        send_frame(i == 0 || $urandom_range(0, 1) == 1, $urandom_range(0, 1) ? 0 : 15);
      drain();
    end

    // oversized width and height words clamp to the largest grid,
    // a short start of a frame each
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    program_grid(32'd2047, 32'd1, pick_size(), pick_origin(), pick_origin());
    for (int i = 0; i < 40; i++) send_word(pick_value(), i == 0);
    drain();
    program_grid(32'd1, 32'd2047, pick_size(), pick_origin(), pick_origin());
    for (int i = 0; i < 40; i++) send_word(pick_value(), i == 0);
    drain();
    program_grid(32'd1024, 32'd1024, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    for (int i = 0; i < 40; i++) send_word(pick_value(), i == 0);

    // tail: everything back, then idle until the final check
    in_tvalid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && model.pending() != 0; n++) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (model.pending() != 0) model.flag_error("verdicts never returned", model.pending(), 0);
    if (model.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fcl_pkg.sv
hdl/fcl_ram.sv
hdl/fcl_front.sv
hdl/fcl_queue.sv
hdl/fcl_back.sv
hdl/frontier_cell_labeler.sv
hdl/fcl_checker.sv
test/frontier_cell_labeler_test.sv
